@@ rtl/core/iir_filter_multichannel_macros.svh @@
// Assertion macros shared by the checker of the multichannel IIR filter.
// Every macro expects signals named clk and rst_n in the scope where it is used.
// No other dependencies.
`ifndef IIR_FILTER_MULTICHANNEL_MACROS_SVH
`define IIR_FILTER_MULTICHANNEL_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IIRMC_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IIRMC_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/iirmc_pkg.sv @@
// Shared types and constants of the multichannel IIR filter.
// Used by the channel interfaces, the MAC unit and the top level. No dependencies.
package iirmc_pkg;

    localparam int CHAN_W    = 3;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 32;
    localparam int COEF_FRAC = 29;
    localparam int PROD_W    = COEF_W + SAMPLE_W;
    localparam int Z_W       = 48;
    localparam int ACC_W     = Z_W + 2;

    localparam int DEF_ORDER    = 3;
    localparam int DEF_CHANNELS = 8;

    // Configuration register file.
    localparam int NREGS  = 7;
    localparam int CFG_AW = 3;

    localparam logic [CFG_AW-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_AW-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_AW-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_AW-1:0] REG_B3 = 3'd3;
    localparam logic [CFG_AW-1:0] REG_A1 = 3'd4;
    localparam logic [CFG_AW-1:0] REG_A2 = 3'd5;
    localparam logic [CFG_AW-1:0] REG_A3 = 3'd6;

    localparam logic [COEF_W-1:0] CFG_RESET [NREGS] = '{
        32'h2000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0
    };

    // Control from the sequencer to the MAC unit.
    typedef struct packed {
        logic load_z;
        logic add_prod;
    } mac_ctrl_t;

    // Results of the MAC unit.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] yq;
        logic                       clip;
        logic signed [Z_W-1:0]      znew;
    } mac_res_t;

endpackage

@@ rtl/core/iirmc_ifs.sv @@
// Valid/ready channel interfaces of the multichannel IIR filter.
// Depends on iirmc_pkg for the payload widths.
interface iirmc_sample_if
    import iirmc_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [CHAN_W-1:0]          chan;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output chan, output sample_in, input ready);
    modport sink (input valid, input chan, input sample_in, output ready);
endinterface

interface iirmc_result_if
    import iirmc_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [CHAN_W-1:0]          chan_out;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;

    modport source (output valid, output chan_out, output sample_out, output clipped,
                    input ready);
    modport sink (input valid, input chan_out, input sample_out, input clipped,
                  output ready);
endinterface

@@ rtl/core/iirmc_mac.sv @@
// Shared multiply-accumulate unit: one registered 32x16 multiplier and an accumulator,
// with output rounding/saturation and delay-state saturation. Depends on iirmc_pkg.
module iirmc_mac
    import iirmc_pkg::*;
(
    input  logic                       clk,
    input  logic signed [COEF_W-1:0]   coef,
    input  logic signed [SAMPLE_W-1:0] opnd,
    input  logic signed [Z_W-1:0]      z_in,
    input  mac_ctrl_t                  ctrl,
    output mac_res_t                   res
);

    localparam logic signed [ACC_W-1:0] HALF     = ACC_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0] Y_MAX    = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Y_MIN    = ACC_W'(-32768);
    localparam logic signed [ACC_W-1:0] ZSAT_MAX = ACC_W'({1'b0, {(Z_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] ZSAT_MIN = -ZSAT_MAX - ACC_W'(1);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  sum;
    logic signed [ACC_W-1:0]  diff;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  yfull;

    assign prod_next = PROD_W'(coef) * PROD_W'(opnd);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctrl.load_z)
        begin
            acc_reg <= ACC_W'(z_in);
        end
        else if (ctrl.add_prod)
        begin
            acc_reg <= sum;
        end
    end

    assign sum   = acc_reg + ACC_W'(prod_reg);
    assign diff  = acc_reg - ACC_W'(prod_reg);
    assign rnd   = sum + HALF;
    assign yfull = rnd >>> COEF_FRAC;

    always_comb
    begin
        res.clip = 1'b0;
        if (yfull > Y_MAX)
        begin
            res.yq   = SAMPLE_W'(Y_MAX);
            res.clip = 1'b1;
        end
        else if (yfull < Y_MIN)
        begin
            res.yq   = SAMPLE_W'(Y_MIN);
            res.clip = 1'b1;
        end
        else
        begin
            res.yq = yfull[SAMPLE_W-1:0];
        end

        if (diff > ZSAT_MAX)
        begin
            res.znew = ZSAT_MAX[Z_W-1:0];
        end
        else if (diff < ZSAT_MIN)
        begin
            res.znew = ZSAT_MIN[Z_W-1:0];
        end
        else
        begin
            res.znew = diff[Z_W-1:0];
        end
    end

endmodule

@@ rtl/core/iirmc_ram.sv @@
// Delay-line memory: one write port and one read port with registered read data.
// No dependencies.
module iirmc_ram #(
    parameter int DEPTH = 24,
    parameter int AW    = 5,
    parameter int W     = 48
)(
    input  logic         clk,
    input  logic         we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/iir_filter_multichannel.sv @@
// Multichannel IIR filter, transposed direct form II, one shared coefficient set.
// Depends on iirmc_pkg, iirmc_ifs, iirmc_mac and iirmc_ram.
//
// Usage:
//   sample_ch carries (chan, sample_in) beats; result_ch returns one beat of
//   (chan_out, sample_out, clipped) for each accepted input beat, in order.
//   Coefficients are written through cfg_we/cfg_idx/cfg_data, Q2.29, while idle.
//   Indexes beyond the last register are ignored.
// Timing:
//   Each sample runs YMUL, YACC, then a TAPA/TAPW pair per tap: one shared multiplier
//   forms b0*x, then b[j]*x and a[j]*y for every tap, one product per cycle.
//   The result enters the output register from the last TAPW, or later from DONE,
//   and the next sample can be accepted in that same cycle.
//   sample_ch.ready is low while a sample is being worked on, until its last TAPW.
// Reset:
//   Coefficients return to b0 = 1.0, others 0; all delay lines read as zero via a
//   per-channel valid bit, so no clearing pass is needed.
// Stall:
//   The result waits in the output register; if it is still held when the next
//   result is done, the block holds that result and stays not ready until the
//   output register frees up.
module iir_filter_multichannel
    import iirmc_pkg::*;
#(
    parameter int ORDER    = DEF_ORDER,
    parameter int CHANNELS = DEF_CHANNELS
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_idx,
    input  logic [COEF_W-1:0]   cfg_data,
    iirmc_sample_if.sink        sample_ch,
    iirmc_result_if.source      result_ch
);

    localparam int DEPTH = CHANNELS * ORDER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TW    = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam int KN    = ORDER + 2;
    localparam int KW    = $clog2(KN);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_YMUL = 6'b000010,
        S_YACC = 6'b000100,
        S_TAPA = 6'b001000,
        S_TAPW = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [TW-1:0]              tap_reg;
    logic [TW-1:0]              tap_next;
    logic [CHAN_W-1:0]          chan_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [AW-1:0]              base_reg;
    logic                       chok_reg;
    logic signed [SAMPLE_W-1:0] yq_reg;
    logic                       clip_reg;
    logic                       vbit_reg [CHANNELS];
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [CHAN_W-1:0]          out_chan_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_clip_reg;
    logic [COEF_W-1:0]          cfg_reg [NREGS];
    logic                       fwd_reg;
    logic signed [Z_W-1:0]      fwd_data_reg;

    logic signed [COEF_W-1:0]   b_tab [KN];
    logic signed [COEF_W-1:0]   a_tab [KN];

    logic                       last_tap;
    logic                       slot_free;
    logic                       in_ready;
    logic                       accept;
    logic                       push;
    logic [CW-1:0]              ch_idx;
    logic                       row_valid;
    logic                       z_ok;
    logic [AW-1:0]              in_base;
    logic                       in_chok;
    logic [AW-1:0]              rd_addr;
    logic [Z_W-1:0]             rd_data;
    logic signed [Z_W-1:0]      rd_z;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic signed [Z_W-1:0]      z_in;
    logic signed [COEF_W-1:0]   mul_coef;
    logic signed [SAMPLE_W-1:0] mul_opnd;
    mac_ctrl_t                  mac_ctrl;
    mac_res_t                   mac_res;

    // Coefficient per tap index; taps above the register set or above ORDER are zero.
    always_comb
    begin
        for (int i = 0; i < KN; i++)
        begin
            b_tab[i] = '0;
            a_tab[i] = '0;
            if (i <= ORDER)
            begin
                case (i)
                    0: b_tab[i] = cfg_reg[REG_B0];
                    1:
                    begin
                        b_tab[i] = cfg_reg[REG_B1];
                        a_tab[i] = cfg_reg[REG_A1];
                    end
                    2:
                    begin
                        b_tab[i] = cfg_reg[REG_B2];
                        a_tab[i] = cfg_reg[REG_A2];
                    end
                    3:
                    begin
                        b_tab[i] = cfg_reg[REG_B3];
                        a_tab[i] = cfg_reg[REG_A3];
                    end
                    default:
                    begin
                        b_tab[i] = '0;
                        a_tab[i] = '0;
                    end
                endcase
            end
        end
    end

    assign last_tap  = (tap_reg == TW'(ORDER - 1));
    assign slot_free = !out_valid_reg || result_ch.ready;
    assign in_ready  = (state_reg == S_IDLE)
                    || (((state_reg == S_TAPW) && last_tap) || (state_reg == S_DONE))
                       && slot_free;
    assign accept    = sample_ch.valid && in_ready;
    assign push      = (((state_reg == S_TAPW) && last_tap) || (state_reg == S_DONE))
                       && slot_free;

    assign in_base = AW'(32'(sample_ch.chan) * 32'(ORDER));
    assign in_chok = (32'(sample_ch.chan) < 32'(CHANNELS));

    assign ch_idx    = CW'(chan_reg);
    assign row_valid = chok_reg && vbit_reg[ch_idx];

    // Delay slot loaded into the accumulator: z0 in YMUL, z1 in YACC, z[j+2] in TAPW.
    // A read issued at the edge that writes the same slot sees the old word, so the
    // new word is forwarded instead.
    always_comb
    begin
        case (state_reg)
            S_YMUL:  z_ok = 1'b1;
            S_YACC:  z_ok = (ORDER > 1);
            S_TAPW:  z_ok = (32'(tap_reg) + 32'd2 < 32'(ORDER));
            default: z_ok = 1'b0;
        endcase
        rd_z = fwd_reg ? fwd_data_reg : $signed(rd_data);
        z_in = (row_valid && z_ok) ? rd_z : '0;
    end

    // The read for a slot is issued in the cycle before it is loaded.
    always_comb
    begin
        if (in_ready)
        begin
            rd_addr = in_base;
        end
        else
        begin
            case (state_reg)
                S_YMUL:  rd_addr = base_reg + AW'(1);
                S_TAPA:  rd_addr = base_reg + AW'(tap_reg) + AW'(2);
                default: rd_addr = base_reg;
            endcase
        end
    end

    assign wr_en   = (state_reg == S_TAPW) && chok_reg;
    assign wr_addr = base_reg + AW'(tap_reg);

    always_comb
    begin
        mul_opnd = x_reg;
        case (state_reg)
            S_YMUL:  mul_coef = b_tab[0];
            S_YACC:  mul_coef = b_tab[1];
            S_TAPA:
            begin
                mul_coef = a_tab[KW'(tap_reg) + KW'(1)];
                mul_opnd = yq_reg;
            end
            S_TAPW:  mul_coef = b_tab[KW'(tap_reg) + KW'(2)];
            default: mul_coef = b_tab[0];
        endcase
    end

    assign mac_ctrl.load_z   = (state_reg == S_YMUL) || (state_reg == S_YACC)
                            || (state_reg == S_TAPW);
    assign mac_ctrl.add_prod = (state_reg == S_TAPA);

    iirmc_mac u_mac (
        .clk  (clk),
        .coef (mul_coef),
        .opnd (mul_opnd),
        .z_in (z_in),
        .ctrl (mac_ctrl),
        .res  (mac_res)
    );

    iirmc_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .W     (Z_W)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (mac_res.znew),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_YMUL;
                end
            end
            S_YMUL: state_next = S_YACC;
            S_YACC:
            begin
                state_next = S_TAPA;
                tap_next   = '0;
            end
            S_TAPA: state_next = S_TAPW;
            S_TAPW:
            begin
                if (!last_tap)
                begin
                    state_next = S_TAPA;
                    tap_next   = tap_reg + TW'(1);
                end
                else if (accept)
                begin
                    state_next = S_YMUL;
                end
                else if (push)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (accept)
                begin
                    state_next = S_YMUL;
                end
                else if (push)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tap_reg       <= '0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                vbit_reg[i] <= 1'b0;
            end
            for (int i = 0; i < NREGS; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            out_valid_reg <= out_valid_next;
            fwd_reg       <= wr_en && (rd_addr == wr_addr);
            if ((state_reg == S_TAPW) && last_tap && chok_reg)
            begin
                vbit_reg[ch_idx] <= 1'b1;
            end
            if (cfg_we && (cfg_idx < CFG_AW'(NREGS)))
            begin
                cfg_reg[cfg_idx] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= mac_res.znew;
        if (accept)
        begin
            chan_reg <= sample_ch.chan;
            x_reg    <= sample_ch.sample_in;
            base_reg <= in_base;
            chok_reg <= in_chok;
        end
        if (state_reg == S_YACC)
        begin
            yq_reg   <= mac_res.yq;
            clip_reg <= mac_res.clip;
        end
        if (push)
        begin
            out_chan_reg   <= chan_reg;
            out_sample_reg <= yq_reg;
            out_clip_reg   <= clip_reg;
        end
    end

    assign sample_ch.ready      = in_ready;
    assign result_ch.valid      = out_valid_reg;
    assign result_ch.chan_out   = out_chan_reg;
    assign result_ch.sample_out = out_sample_reg;
    assign result_ch.clipped    = out_clip_reg;

endmodule

@@ rtl/core/iirmc_checker.sv @@
// Port-level checker for the multichannel IIR filter, bound to the top level.
// Depends on iirmc_pkg and iir_filter_multichannel_macros.svh.
`include "iir_filter_multichannel_macros.svh"

module iirmc_port_checker
    import iirmc_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [CHAN_W-1:0]          out_chan,
    input logic signed [SAMPLE_W-1:0] out_sample,
    input logic                       out_clipped
);

    logic                       in_beat;
    logic                       out_stall;
    logic                       on_rail;
    logic [CHAN_W+SAMPLE_W:0]   out_beat;

    assign in_beat   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;
    assign on_rail   = (out_sample == 16'sh7FFF) || (out_sample == 16'sh8000);
    assign out_beat  = {out_chan, out_sample, out_clipped};

    // A sample is worked on over several states, so ready drops right after a beat.
    `IIRMC_CHECK_NEXT(busy_after_accept, in_beat, !in_ready, "ready high after accept")

    // A result never rises too early after an input beat, as checked through $past.
    `IIRMC_CHECK(no_early_result, $rose(out_valid), !$past(in_beat, 2), "result too early")

    // A clipped result sits at one of the two rails.
    `IIRMC_CHECK(clip_at_rail, out_valid && out_clipped, on_rail, "clipped off rail")

    `IIRMC_CHECK_NEXT(out_hold, out_stall, out_valid && $stable(out_beat), "held beat changed")

endmodule

bind iir_filter_multichannel iirmc_port_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample_ch.valid),
    .in_ready    (sample_ch.ready),
    .out_valid   (result_ch.valid),
    .out_ready   (result_ch.ready),
    .out_chan    (result_ch.chan_out),
    .out_sample  (result_ch.sample_out),
    .out_clipped (result_ch.clipped)
);
